// ===== sv/crss_pkg.sv =====
// Shared types and constants for the climate ramp and storm sequencer.
`default_nettype none

package crss_pkg;

   localparam int unsigned LEVEL_W = 17;
   localparam int unsigned STEP_W  = 20;
   localparam int unsigned CALC_W  = 22;
   localparam int unsigned RATE_W  = 10;
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned DATA_W  = 32;

   localparam logic [RATE_W-1:0]  FAN_RATE         = 10'd15;
   localparam logic [6:0]         FLASH_LEVEL      = 7'd70;
   localparam logic [6:0]         MIST_HUMIDITY    = 7'd70;
   localparam logic [LEVEL_W-1:0] LAMP_STORM_LEVEL = 17'd20000;
   localparam logic [LEVEL_W-1:0] FULL_LEVEL       = 17'd100000;
   localparam logic [LEVEL_W-1:0] FAN_RESET_LEVEL  = 17'd20000;
   localparam logic [TIME_W-1:0]  ELAPSED_MAX      = 16'hFFFF;

   localparam logic [4:0] HOUR_DAWN      = 5'd9;
   localparam logic [4:0] HOUR_MIST_FROM = 5'd10;
   localparam logic [4:0] HOUR_DUSK      = 5'd20;

   typedef enum logic [2:0] {
      REG_LAMP_RATE        = 3'd0,
      REG_VOLUME_UP_RATE   = 3'd1,
      REG_VOLUME_DOWN_RATE = 3'd2,
      REG_STORM_HOLD_MS    = 3'd3,
      REG_TEMP_HIGH        = 3'd4,
      REG_TEMP_LOW         = 3'd5,
      REG_FAN_MAX          = 3'd6,
      REG_FAN_MIN          = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic        [RATE_W-1:0]  lamp_rate;
      logic        [RATE_W-1:0]  volume_up_rate;
      logic        [RATE_W-1:0]  volume_down_rate;
      logic        [TIME_W-1:0]  storm_hold_ms;
      logic signed [11:0]        temp_high;
      logic signed [11:0]        temp_low;
      logic        [LEVEL_W-1:0] fan_max;
      logic        [LEVEL_W-1:0] fan_min;
   } cfg_type;

   typedef struct packed {
      logic [9:0]         dt_ms;
      logic signed [11:0] temperature;
      logic [6:0]         humidity;
      logic [4:0]         hour;
      logic [6:0]         mic_level;
      logic               storm_start;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] lamp_power;
      logic [LEVEL_W-1:0] fan_speed;
      logic [LEVEL_W-1:0] storm_volume;
      logic               mist_on;
      logic               main_light_on;
      logic               flash_on;
      logic               storm_active;
   } rsp_type;

   typedef struct packed {
      req_type            item;
      logic [STEP_W-1:0]  fan_step;
      logic [STEP_W-1:0]  lamp_step;
      logic [STEP_W-1:0]  up_step;
      logic [STEP_W-1:0]  down_step;
   } stage_type;

endpackage

`default_nettype wire

// ===== sv/crss_csr.sv =====
// Configuration register file with APB-style access.
`default_nettype none

module crss_csr
   import crss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx        = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_LAMP_RATE:        cfg_in.lamp_rate        = csr_pwdata[RATE_W-1:0];
            REG_VOLUME_UP_RATE:   cfg_in.volume_up_rate   = csr_pwdata[RATE_W-1:0];
            REG_VOLUME_DOWN_RATE: cfg_in.volume_down_rate = csr_pwdata[RATE_W-1:0];
            REG_STORM_HOLD_MS:    cfg_in.storm_hold_ms    = csr_pwdata[TIME_W-1:0];
            REG_TEMP_HIGH:        cfg_in.temp_high        = signed'(csr_pwdata[11:0]);
            REG_TEMP_LOW:         cfg_in.temp_low         = signed'(csr_pwdata[11:0]);
            REG_FAN_MAX:          cfg_in.fan_max          = csr_pwdata[LEVEL_W-1:0];
            REG_FAN_MIN:          cfg_in.fan_min          = csr_pwdata[LEVEL_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_LAMP_RATE:        csr_prdata = DATA_W'(cfg_ff.lamp_rate);
         REG_VOLUME_UP_RATE:   csr_prdata = DATA_W'(cfg_ff.volume_up_rate);
         REG_VOLUME_DOWN_RATE: csr_prdata = DATA_W'(cfg_ff.volume_down_rate);
         REG_STORM_HOLD_MS:    csr_prdata = DATA_W'(cfg_ff.storm_hold_ms);
         REG_TEMP_HIGH:        csr_prdata = DATA_W'(cfg_ff.temp_high);
         REG_TEMP_LOW:         csr_prdata = DATA_W'(cfg_ff.temp_low);
         REG_FAN_MAX:          csr_prdata = DATA_W'(cfg_ff.fan_max);
         REG_FAN_MIN:          csr_prdata = DATA_W'(cfg_ff.fan_min);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lamp_rate        <= 10'd15;
         cfg_ff.volume_up_rate   <= 10'd15;
         cfg_ff.volume_down_rate <= 10'd5;
         cfg_ff.storm_hold_ms    <= 16'd5000;
         cfg_ff.temp_high        <= 12'sd240;
         cfg_ff.temp_low         <= 12'sd200;
         cfg_ff.fan_max          <= 17'd80000;
         cfg_ff.fan_min          <= 17'd20000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/crss_in_stage.sv =====
// Input register: captures a tick and its ramp steps (rate times dt).
`default_nettype none

module crss_in_stage
   import crss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  cfg_type      cfg,
   input  wire logic    take,
   output logic         stage_valid,
   output stage_type    stage_data
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   logic      load;

   assign req_stall   = valid_ff && !take;
   assign load        = req_valid && !req_stall;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_comb begin
      data_in.item      = req_data;
      data_in.fan_step  = STEP_W'(FAN_RATE) * STEP_W'(req_data.dt_ms);
      data_in.lamp_step = STEP_W'(cfg.lamp_rate) * STEP_W'(req_data.dt_ms);
      data_in.up_step   = STEP_W'(cfg.volume_up_rate) * STEP_W'(req_data.dt_ms);
      data_in.down_step = STEP_W'(cfg.volume_down_rate) * STEP_W'(req_data.dt_ms);
      valid_in          = load || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/crss_core.sv =====
// Tick update: fan, storm and time-of-day steps in one combinational pass, with the result register.
`default_nettype none

module crss_core
   import crss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    stage_valid,
   input  stage_type    stage_data,
   input  cfg_type      cfg,
   output logic         take,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [LEVEL_W-1:0] lamp_ff, lamp_in;
   logic [LEVEL_W-1:0] fan_ff, fan_in;
   logic [LEVEL_W-1:0] vol_ff, vol_in;
   logic               mist_ff, mist_in;
   logic               light_ff, light_in;
   logic               flash_ff, flash_in;
   logic               run_ff, run_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   assign take      = stage_valid && (!out_valid_ff || !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic signed [CALC_W-1:0] lamp;
      logic signed [CALC_W-1:0] fan;
      logic signed [CALC_W-1:0] vol;
      logic signed [CALC_W-1:0] fstep;
      logic signed [CALC_W-1:0] lstep;
      logic signed [CALC_W-1:0] ustep;
      logic signed [CALC_W-1:0] dstep;
      logic [TIME_W:0]          esum;
      logic                     in_hold;
      logic                     done;
      req_type                  it;

      it    = stage_data.item;
      lamp  = signed'(CALC_W'(lamp_ff));
      fan   = signed'(CALC_W'(fan_ff));
      vol   = signed'(CALC_W'(vol_ff));
      fstep = signed'(CALC_W'(stage_data.fan_step));
      lstep = signed'(CALC_W'(stage_data.lamp_step));
      ustep = signed'(CALC_W'(stage_data.up_step));
      dstep = signed'(CALC_W'(stage_data.down_step));
      mist_in    = mist_ff;
      light_in   = light_ff;
      flash_in   = flash_ff;
      run_in     = run_ff;
      elapsed_in = elapsed_ff;
      done       = 1'b0;
      esum       = {1'b0, elapsed_ff} + (TIME_W+1)'(it.dt_ms);

      // storm timer
      if (it.storm_start) begin
         run_in     = 1'b1;
         elapsed_in = '0;
      end else if (run_ff) begin
         elapsed_in = esum[TIME_W] ? ELAPSED_MAX : esum[TIME_W-1:0];
      end

      // fan
      if (it.temperature > cfg.temp_high) begin
         if (fan + fstep < signed'(CALC_W'(cfg.fan_max))) begin
            fan = fan + fstep;
         end else begin
            fan = signed'(CALC_W'(cfg.fan_max));
         end
      end else if (it.temperature < cfg.temp_low) begin
         if (fan - fstep > signed'(CALC_W'(cfg.fan_min))) begin
            fan = fan - fstep;
         end else begin
            fan = signed'(CALC_W'(cfg.fan_min));
         end
      end

      // storm sequence
      in_hold = elapsed_in < cfg.storm_hold_ms;
      if (run_in) begin
         light_in = 1'b0;
         if (lamp - lstep > signed'(CALC_W'(LAMP_STORM_LEVEL))) begin
            if (in_hold) begin
               lamp       = lamp - lstep;
               elapsed_in = '0;
               done       = 1'b1;
            end
         end else if (in_hold) begin
            lamp = signed'(CALC_W'(LAMP_STORM_LEVEL));
         end
         if (!done) begin
            flash_in = it.mic_level > FLASH_LEVEL;
            if (vol + ustep < signed'(CALC_W'(FULL_LEVEL))) begin
               if (in_hold) begin
                  vol        = vol + ustep;
                  elapsed_in = '0;
                  done       = 1'b1;
               end
            end else if (in_hold) begin
               vol = signed'(CALC_W'(FULL_LEVEL));
            end
         end
         if (!done) begin
            mist_in = 1'b1;
            done    = in_hold;
         end
         if (!done) begin
            if (vol - dstep > 0) begin
               vol = vol - dstep;
            end else begin
               vol     = '0;
               mist_in = 1'b0;
               if (lamp + lstep < signed'(CALC_W'(FULL_LEVEL))) begin
                  lamp = lamp + lstep;
               end else begin
                  lamp     = signed'(CALC_W'(FULL_LEVEL));
                  light_in = 1'b1;
                  run_in   = 1'b0;
                  flash_in = 1'b0;
               end
            end
         end
      end

      // time of day
      if (it.hour == HOUR_DAWN) begin
         if (lamp + lstep < signed'(CALC_W'(FULL_LEVEL))) begin
            lamp = lamp + lstep;
         end else begin
            lamp     = signed'(CALC_W'(FULL_LEVEL));
            light_in = 1'b1;
         end
      end else if (it.hour >= HOUR_MIST_FROM && it.hour < HOUR_DUSK) begin
         mist_in = it.humidity < MIST_HUMIDITY;
      end else if (it.hour == HOUR_DUSK) begin
         if (lamp == signed'(CALC_W'(FULL_LEVEL))) begin
            light_in = 1'b0;
         end
         if (lamp - lstep > 0) begin
            lamp = lamp - lstep;
         end else begin
            lamp = '0;
         end
      end

      lamp_in = lamp[LEVEL_W-1:0];
      fan_in  = fan[LEVEL_W-1:0];
      vol_in  = vol[LEVEL_W-1:0];

      out_in.lamp_power    = lamp_in;
      out_in.fan_speed     = fan_in;
      out_in.storm_volume  = vol_in;
      out_in.mist_on       = mist_in;
      out_in.main_light_on = light_in;
      out_in.flash_on      = flash_in;
      out_in.storm_active  = run_in;

      out_valid_in = take || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_ff      <= '0;
         fan_ff       <= FAN_RESET_LEVEL;
         vol_ff       <= '0;
         mist_ff      <= 1'b0;
         light_ff     <= 1'b0;
         flash_ff     <= 1'b0;
         run_ff       <= 1'b0;
         elapsed_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            lamp_ff    <= lamp_in;
            fan_ff     <= fan_in;
            vol_ff     <= vol_in;
            mist_ff    <= mist_in;
            light_ff   <= light_in;
            flash_ff   <= flash_in;
            run_ff     <= run_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/climate_ramp_and_storm_sequencer.sv =====
// Climate ramp and storm sequencer: top level.
//
// Each beat on the req_ channel is one control tick (dt, temperature, humidity,
// hour, mic level, storm start); each produces exactly one beat on the rsp_
// channel with lamp, fan and volume levels in milli-percent and the relay bits.
// A beat is taken on a rising edge with valid high and stall low.
// The request beat is held in the input register and its result then in the
// result register. Throughput: one tick per cycle while rsp_stall is low,
// set by the single update pass from the input register to the result register.
// The result register frees the input side: a new tick is taken while a result
// waits. While rsp_stall is high and a result is held, the input register fills
// and req_stall rises until the result beat is taken.
// Registers sit on the csr_ port at byte addresses 4*i; write only while idle.
// Synchronous reset returns the registers to their defaults, the lamp and
// volume to zero, the fan to 20000 and the storm to inactive.
`default_nettype none

module climate_ramp_and_storm_sequencer
   import crss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type   cfg;
   logic      stage_valid;
   stage_type stage_data;
   logic      take;

   crss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crss_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .cfg         (cfg),
      .take        (take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   crss_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .cfg         (cfg),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
